// ===== rtl/core/desba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES avalanche package
// Permutation tables, S-boxes and round functions shared by the DES pipeline.
// ----------------------------------------------------------------------------
package desba_pkg;

  localparam int unsigned NUM_ROUNDS = 16;
  localparam int unsigned HALF_KEY_W = 28;
  localparam int unsigned NUM_SBOX   = 8;

  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
    6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam logic [1:0] ROT_TAB [NUM_ROUNDS] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  localparam logic [3:0] SBOX [NUM_SBOX][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
  };

  function automatic logic [63:0] ip_perm(input logic [63:0] v);
    logic [63:0] o;
    logic [5:0]  idx;
    for (int i = 0; i < 64; i++) begin
      idx        = 6'(7'd64 - IP_TAB[i]);
      o[63 - i]  = v[idx];
    end
    return o;
  endfunction

  function automatic logic [63:0] fp_perm(input logic [63:0] v);
    logic [63:0] o;
    logic [5:0]  idx;
    for (int i = 0; i < 64; i++) begin
      idx        = 6'(7'd64 - FP_TAB[i]);
      o[63 - i]  = v[idx];
    end
    return o;
  endfunction

  function automatic logic [55:0] pc1_perm(input logic [63:0] v);
    logic [55:0] o;
    logic [5:0]  idx;
    for (int i = 0; i < 56; i++) begin
      idx        = 6'(7'd64 - PC1_TAB[i]);
      o[55 - i]  = v[idx];
    end
    return o;
  endfunction

  function automatic logic [47:0] pc2_perm(input logic [55:0] v);
    logic [47:0] o;
    logic [5:0]  idx;
    for (int i = 0; i < 48; i++) begin
      idx        = 6'd56 - PC2_TAB[i];
      o[47 - i]  = v[idx];
    end
    return o;
  endfunction

  function automatic logic [HALF_KEY_W-1:0] rotl_half(input logic [HALF_KEY_W-1:0] v,
                                                      input logic [1:0] s);
    return (s == 2'd2) ? {v[HALF_KEY_W-3:0], v[HALF_KEY_W-1 -: 2]}
                       : {v[HALF_KEY_W-2:0], v[HALF_KEY_W-1]};
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] subkey);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] o;
    logic [5:0]  six;
    logic [4:0]  idx;
    for (int i = 0; i < 48; i++) begin
      idx       = 5'(6'd32 - E_TAB[i]);
      x[47 - i] = r[idx];
    end
    x = x ^ subkey;
    for (int i = 0; i < NUM_SBOX; i++) begin
      six               = x[47 - 6*i -: 6];
      s[31 - 4*i -: 4]  = SBOX[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) begin
      idx       = 5'(6'd32 - P_TAB[i]);
      o[31 - i] = s[idx];
    end
    return o;
  endfunction

  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/des_block_encrypt_avalanche_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES block encrypt with avalanche count
// Stages: IP/PC-1 stage, sixteen round stages, count stage, output stage.
// Throughput: one item per cycle while the output is not stalled; a stalled
//   output holds the full stages and lets items advance into empty ones.
// Reset clears all stage valid bits and the reference ciphertext to zero.
// ----------------------------------------------------------------------------
module des_block_encrypt_avalanche_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] plaintext_i,
  input  logic [63:0] cipher_key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] ciphertext_o,
  output logic [6:0]  changed_bits_o,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i
);

  localparam int unsigned NR     = desba_pkg::NUM_ROUNDS;
  localparam int unsigned HW     = desba_pkg::HALF_KEY_W;
  localparam int unsigned CNT_S  = NR + 1;
  localparam int unsigned OUT_S  = NR + 2;
  localparam int unsigned NSTG   = NR + 3;

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] rdy;
  logic [63:0]     ref_q;

  logic [31:0]   l_q [NR+1];
  logic [31:0]   r_q [NR+1];
  logic [HW-1:0] c_q [NR+1];
  logic [HW-1:0] d_q [NR+1];

  logic [63:0] ct_q;
  logic [3:0]  bcnt_q [8];
  logic [63:0] ct_out_q;
  logic [6:0]  chg_q;

  logic [63:0] ip_d;
  logic [55:0] cd_d;
  logic [63:0] ct_d;
  logic [63:0] diff_d;
  logic [6:0]  chg_d;

  // Ready ripples back: a stage loads when empty or when its successor loads
  assign rdy[OUT_S] = out_ready_i | ~vld_q[OUT_S];
  for (genvar s = 0; s < NSTG - 1; s++) begin : g_rdy
    assign rdy[s] = rdy[s+1] | ~vld_q[s];
  end

  assign in_ready_o     = rdy[0];
  assign out_valid_o    = vld_q[OUT_S];
  assign ciphertext_o   = ct_out_q;
  assign changed_bits_o = chg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ref_q <= '0;
    end else begin
      if (cfg_we_i) begin
        ref_q <= cfg_wdata_i;
      end
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // Entry stage: initial permutation and PC-1
  always_comb begin
    ip_d = desba_pkg::ip_perm(plaintext_i);
    cd_d = desba_pkg::pc1_perm(cipher_key_i);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      l_q[0] <= ip_d[63:32];
      r_q[0] <= ip_d[31:0];
      c_q[0] <= cd_d[55:28];
      d_q[0] <= cd_d[27:0];
    end
  end

  // Round stages
  for (genvar k = 1; k <= NR; k++) begin : g_round
    logic [HW-1:0] c_d;
    logic [HW-1:0] d_d;
    logic [47:0]   sk_d;
    logic [31:0]   r_d;

    always_comb begin
      c_d  = desba_pkg::rotl_half(c_q[k-1], desba_pkg::ROT_TAB[k-1]);
      d_d  = desba_pkg::rotl_half(d_q[k-1], desba_pkg::ROT_TAB[k-1]);
      sk_d = desba_pkg::pc2_perm({c_d, d_d});
      r_d  = l_q[k-1] ^ desba_pkg::feistel(r_q[k-1], sk_d);
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        l_q[k] <= r_q[k-1];
        r_q[k] <= r_d;
        c_q[k] <= c_d;
        d_q[k] <= d_d;
      end
    end
  end

  // Count stage: final swap, inverse IP, per-byte difference counts
  always_comb begin
    ct_d   = desba_pkg::fp_perm({r_q[NR], l_q[NR]});
    diff_d = ct_d ^ ref_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[CNT_S]) begin
      ct_q <= ct_d;
      for (int b = 0; b < 8; b++) begin
        bcnt_q[b] <= desba_pkg::popcnt8(diff_d[8*b +: 8]);
      end
    end
  end

  // Output stage: sum the byte counts
  always_comb begin
    chg_d = '0;
    for (int b = 0; b < 8; b++) begin
      chg_d = chg_d + 7'(bcnt_q[b]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[OUT_S]) begin
      ct_out_q <= ct_q;
      chg_q    <= chg_d;
    end
  end

endmodule
